@@ rtl/frwa_pkg.sv @@
// Shared constants, types and the control-store program of the frame rate window averager.
package frwa_pkg;

    // Sizing of the sample history and the averaging windows.
    localparam int HISTORY_DEPTH = 80;
    localparam int SHORT_WINDOW  = 20;
    localparam int MIDDLE_WINDOW = 40;

    // Field widths.
    localparam int RATE_W   = 24;
    localparam int SPS_W    = 7;
    localparam int FRAMES_W = 18;
    localparam int COUNT_W  = 32;

    localparam logic [SPS_W-1:0] SPS_RESET = SPS_W'(4);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

    // A window longer than the ring never fills; its read offset is clamped.
    localparam bit SHORT_IN_RING  = (SHORT_WINDOW <= HISTORY_DEPTH);
    localparam bit MIDDLE_IN_RING = (MIDDLE_WINDOW <= HISTORY_DEPTH);
    localparam int SHORT_OFS  = SHORT_IN_RING ? SHORT_WINDOW : HISTORY_DEPTH;
    localparam int MIDDLE_OFS = MIDDLE_IN_RING ? MIDDLE_WINDOW : HISTORY_DEPTH;

    localparam int SHORT_SUM_W  = RATE_W + $clog2(SHORT_WINDOW + 1);
    localparam int MIDDLE_SUM_W = RATE_W + $clog2(MIDDLE_WINDOW + 1);
    localparam int LONG_SUM_W   = RATE_W + $clog2(HISTORY_DEPTH + 1);
    localparam int GRAND_SUM_W  = RATE_W + COUNT_W;

    // Shared divider: the quotient always fits in RATE_W bits.
    localparam int DIVIDEND_W = GRAND_SUM_W;
    localparam int DIVISOR_W  = COUNT_W;
    localparam int QUO_W      = RATE_W;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

    // Control store addressing.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_WAIT       = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_CHECK      = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LD_RELOAD  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_WT_RELOAD  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_ST_RELOAD  = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_UPD_SHORT  = STEP_W'(5);
    localparam logic [STEP_W-1:0] STEP_UPD_MIDDLE = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_UPD_LONG   = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_LD_SHORT   = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_WT_SHORT   = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_ST_SHORT   = STEP_W'(10);
    localparam logic [STEP_W-1:0] STEP_LD_MIDDLE  = STEP_W'(11);
    localparam logic [STEP_W-1:0] STEP_WT_MIDDLE  = STEP_W'(12);
    localparam logic [STEP_W-1:0] STEP_ST_MIDDLE  = STEP_W'(13);
    localparam logic [STEP_W-1:0] STEP_LD_LONG    = STEP_W'(14);
    localparam logic [STEP_W-1:0] STEP_WT_LONG    = STEP_W'(15);
    localparam logic [STEP_W-1:0] STEP_ST_LONG    = STEP_W'(16);
    localparam logic [STEP_W-1:0] STEP_LD_GRAND   = STEP_W'(17);
    localparam logic [STEP_W-1:0] STEP_WT_GRAND   = STEP_W'(18);
    localparam logic [STEP_W-1:0] STEP_ST_GRAND   = STEP_W'(19);
    localparam logic [STEP_W-1:0] STEP_EMIT       = STEP_W'(20);
    localparam logic [STEP_W-1:0] STEP_RETURN     = STEP_W'(21);

    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CHECK,
        OP_LD_RELOAD,
        OP_DIV_WAIT,
        OP_ST_RELOAD,
        OP_UPD_SHORT,
        OP_UPD_MIDDLE,
        OP_UPD_LONG,
        OP_LD_SHORT,
        OP_ST_SHORT,
        OP_LD_MIDDLE,
        OP_ST_MIDDLE,
        OP_LD_LONG,
        OP_ST_LONG,
        OP_LD_GRAND,
        OP_ST_GRAND,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_NO_SAMPLE,
        COND_DIV_BUSY,
        COND_SHORT_SKIP,
        COND_MIDDLE_SKIP,
        COND_LONG_SKIP,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic no_item;
        logic no_sample;
        logic div_busy;
        logic short_skip;
        logic middle_skip;
        logic long_skip;
        logic out_busy;
    } t_status;

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic [STEP_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The program: one control word per step; the jump is taken when the condition holds.
    function automatic t_uword ucode_word(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_WAIT:       w = uw(OP_ACCEPT,     COND_NO_ITEM,     STEP_WAIT);
            STEP_CHECK:      w = uw(OP_CHECK,      COND_NO_SAMPLE,   STEP_EMIT);
            STEP_LD_RELOAD:  w = uw(OP_LD_RELOAD,  COND_NEVER,       STEP_WAIT);
            STEP_WT_RELOAD:  w = uw(OP_DIV_WAIT,   COND_DIV_BUSY,    STEP_WT_RELOAD);
            STEP_ST_RELOAD:  w = uw(OP_ST_RELOAD,  COND_NEVER,       STEP_WAIT);
            STEP_UPD_SHORT:  w = uw(OP_UPD_SHORT,  COND_NEVER,       STEP_WAIT);
            STEP_UPD_MIDDLE: w = uw(OP_UPD_MIDDLE, COND_NEVER,       STEP_WAIT);
            STEP_UPD_LONG:   w = uw(OP_UPD_LONG,   COND_NEVER,       STEP_WAIT);
            STEP_LD_SHORT:   w = uw(OP_LD_SHORT,   COND_SHORT_SKIP,  STEP_LD_MIDDLE);
            STEP_WT_SHORT:   w = uw(OP_DIV_WAIT,   COND_DIV_BUSY,    STEP_WT_SHORT);
            STEP_ST_SHORT:   w = uw(OP_ST_SHORT,   COND_NEVER,       STEP_WAIT);
            STEP_LD_MIDDLE:  w = uw(OP_LD_MIDDLE,  COND_MIDDLE_SKIP, STEP_LD_LONG);
            STEP_WT_MIDDLE:  w = uw(OP_DIV_WAIT,   COND_DIV_BUSY,    STEP_WT_MIDDLE);
            STEP_ST_MIDDLE:  w = uw(OP_ST_MIDDLE,  COND_NEVER,       STEP_WAIT);
            STEP_LD_LONG:    w = uw(OP_LD_LONG,    COND_LONG_SKIP,   STEP_LD_GRAND);
            STEP_WT_LONG:    w = uw(OP_DIV_WAIT,   COND_DIV_BUSY,    STEP_WT_LONG);
            STEP_ST_LONG:    w = uw(OP_ST_LONG,    COND_NEVER,       STEP_WAIT);
            STEP_LD_GRAND:   w = uw(OP_LD_GRAND,   COND_NEVER,       STEP_WAIT);
            STEP_WT_GRAND:   w = uw(OP_DIV_WAIT,   COND_DIV_BUSY,    STEP_WT_GRAND);
            STEP_ST_GRAND:   w = uw(OP_ST_GRAND,   COND_NEVER,       STEP_WAIT);
            STEP_EMIT:       w = uw(OP_EMIT,       COND_OUT_BUSY,    STEP_EMIT);
            STEP_RETURN:     w = uw(OP_NOP,        COND_ALWAYS,      STEP_WAIT);
            default:         w = uw(OP_NOP,        COND_ALWAYS,      STEP_WAIT);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/frwa_div.sv @@
// Radix-2 restoring divider that produces one quotient bit per cycle.
module frwa_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [frwa_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [frwa_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                            o_busy,
    output logic [frwa_pkg::QUO_W-1:0]      o_quotient
);
    import frwa_pkg::*;

    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] n_rem;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // The upper dividend bits start as the remainder; the caller guarantees
    // they are below the divisor, so the quotient fits in QUO_W bits.
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        diff  = trial - {1'b0, r_divisor};
        fits  = (trial >= {1'b0, r_divisor});
        n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(QUO_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_dividend[DIVIDEND_W-1:QUO_W];
            r_quo     <= i_dividend[QUO_W-1:0];
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

@@ rtl/frwa_useq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module frwa_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frwa_pkg::t_status i_status,
    output frwa_pkg::t_ctrl   o_ctrl
);
    import frwa_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            word;
    logic              take;

    always_comb begin
        word = ucode_word(r_step);
        case (word.cond)
            COND_NEVER:       take = 1'b0;
            COND_ALWAYS:      take = 1'b1;
            COND_NO_ITEM:     take = i_status.no_item;
            COND_NO_SAMPLE:   take = i_status.no_sample;
            COND_DIV_BUSY:    take = i_status.div_busy;
            COND_SHORT_SKIP:  take = i_status.short_skip;
            COND_MIDDLE_SKIP: take = i_status.middle_skip;
            COND_LONG_SKIP:   take = i_status.long_skip;
            COND_OUT_BUSY:    take = i_status.out_busy;
            default:          take = 1'b0;
        endcase
        n_step    = take ? word.target : r_step + STEP_W'(1);
        o_ctrl.op = word.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ rtl/frwa_datapath.sv @@
// Datapath: countdown, history ring, window and grand sums, divider, held and output registers.
module frwa_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  frwa_pkg::t_ctrl             i_ctrl,
    input  logic                        i_cfg_wr_en,
    input  logic [frwa_pkg::SPS_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    input  logic [frwa_pkg::RATE_W-1:0] i_frame_rate,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output logic                        o_updated,
    output logic [frwa_pkg::RATE_W-1:0] o_current_rate,
    output logic [frwa_pkg::RATE_W-1:0] o_short_average,
    output logic [frwa_pkg::RATE_W-1:0] o_middle_average,
    output logic [frwa_pkg::RATE_W-1:0] o_long_average,
    output logic [frwa_pkg::RATE_W-1:0] o_overall_average,
    output frwa_pkg::t_status           o_status
);
    import frwa_pkg::*;

    logic [SPS_W-1:0]           r_sps;
    logic [RATE_W-1:0]          r_rate;
    logic signed [FRAMES_W-1:0] r_frames_left;
    logic                       r_updated;

    logic [RATE_W-1:0]       r_ring [HISTORY_DEPTH];
    logic [RATE_W-1:0]       r_rd_data;
    logic [SLOT_W-1:0]       rd_addr;
    logic                    rd_en;
    logic                    wr_en;
    logic [SLOT_W-1:0]       r_slot;
    logic [FILL_W-1:0]       r_fill;

    logic [SHORT_SUM_W-1:0]  r_short_sum;
    logic [MIDDLE_SUM_W-1:0] r_middle_sum;
    logic [LONG_SUM_W-1:0]   r_long_sum;
    logic [GRAND_SUM_W-1:0]  r_grand_sum;
    logic [COUNT_W-1:0]      r_grand_count;

    logic [RATE_W-1:0] r_held_current;
    logic [RATE_W-1:0] r_held_short;
    logic [RATE_W-1:0] r_held_middle;
    logic [RATE_W-1:0] r_held_long;
    logic [RATE_W-1:0] r_held_overall;

    logic              r_out_valid;
    logic              r_o_updated;
    logic [RATE_W-1:0] r_o_current;
    logic [RATE_W-1:0] r_o_short;
    logic [RATE_W-1:0] r_o_middle;
    logic [RATE_W-1:0] r_o_long;
    logic [RATE_W-1:0] r_o_overall;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_busy;
    logic [QUO_W-1:0]      div_quotient;

    logic [SPS_W-1:0]  sps_eff;
    logic [RATE_W-1:0] drop_sample;
    logic              short_full;
    logic              middle_full;
    logic              long_full;
    logic              in_accept;
    logic              emit;

    assign o_in_ready = (i_ctrl.op == OP_ACCEPT);
    assign in_accept  = i_in_valid && o_in_ready;
    assign emit       = (i_ctrl.op == OP_EMIT) && !o_status.out_busy;
    assign sps_eff    = (r_sps == '0) ? SPS_W'(1) : r_sps;

    // Fill tests against the current count (before the increment during the
    // sum updates, after it for the averages).
    assign short_full  = SHORT_IN_RING && (32'(r_fill) >= SHORT_WINDOW);
    assign middle_full = MIDDLE_IN_RING && (32'(r_fill) >= MIDDLE_WINDOW);
    assign long_full   = (32'(r_fill) >= HISTORY_DEPTH);

    // Sample that leaves the window; the entry read from the ring counts only when the window is full.
    always_comb begin
        case (i_ctrl.op)
            OP_UPD_SHORT:  drop_sample = short_full ? r_rd_data : '0;
            OP_UPD_MIDDLE: drop_sample = middle_full ? r_rd_data : '0;
            OP_UPD_LONG:   drop_sample = long_full ? r_rd_data : '0;
            default:       drop_sample = '0;
        endcase
    end

    always_comb begin
        o_status.no_item     = !i_in_valid;
        o_status.no_sample   = (r_frames_left >= FRAMES_W'(1));
        o_status.div_busy    = div_busy;
        o_status.short_skip  = !short_full;
        o_status.middle_skip = !middle_full;
        o_status.long_skip   = !long_full;
        o_status.out_busy    = r_out_valid && !i_out_ready;
    end

    // Ring read addresses trail the write slot by each window length.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_slot;
        wr_en   = (i_ctrl.op == OP_UPD_LONG);
        case (i_ctrl.op)
            OP_ST_RELOAD: begin
                rd_en   = 1'b1;
                rd_addr = (r_slot >= SLOT_W'(SHORT_OFS)) ? r_slot - SLOT_W'(SHORT_OFS)
                        : r_slot + SLOT_W'(HISTORY_DEPTH - SHORT_OFS);
            end
            OP_UPD_SHORT: begin
                rd_en   = 1'b1;
                rd_addr = (r_slot >= SLOT_W'(MIDDLE_OFS)) ? r_slot - SLOT_W'(MIDDLE_OFS)
                        : r_slot + SLOT_W'(HISTORY_DEPTH - MIDDLE_OFS);
            end
            OP_UPD_MIDDLE: begin
                rd_en   = 1'b1;
                rd_addr = r_slot;
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_slot] <= r_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = DIVISOR_W'(1);
        case (i_ctrl.op)
            OP_LD_RELOAD: begin
                div_start    = 1'b1;
                div_dividend = DIVIDEND_W'(r_rate[RATE_W-1:8]);
                div_divisor  = DIVISOR_W'(sps_eff);
            end
            OP_LD_SHORT: begin
                div_start    = 1'b1;
                div_dividend = DIVIDEND_W'(r_short_sum);
                div_divisor  = DIVISOR_W'(SHORT_WINDOW);
            end
            OP_LD_MIDDLE: begin
                div_start    = 1'b1;
                div_dividend = DIVIDEND_W'(r_middle_sum);
                div_divisor  = DIVISOR_W'(MIDDLE_WINDOW);
            end
            OP_LD_LONG: begin
                div_start    = 1'b1;
                div_dividend = DIVIDEND_W'(r_long_sum);
                div_divisor  = DIVISOR_W'(HISTORY_DEPTH);
            end
            OP_LD_GRAND: begin
                div_start    = 1'b1;
                div_dividend = r_grand_sum;
                div_divisor  = r_grand_count;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    frwa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rate <= i_frame_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps          <= SPS_RESET;
            r_frames_left  <= '0;
            r_updated      <= 1'b0;
            r_slot         <= '0;
            r_fill         <= '0;
            r_short_sum    <= '0;
            r_middle_sum   <= '0;
            r_long_sum     <= '0;
            r_grand_sum    <= '0;
            r_grand_count  <= '0;
            r_held_current <= '0;
            r_held_short   <= '0;
            r_held_middle  <= '0;
            r_held_long    <= '0;
            r_held_overall <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sps <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_frames_left <= r_frames_left - FRAMES_W'(1);
            end
            case (i_ctrl.op)
                OP_CHECK: begin
                    r_updated <= !o_status.no_sample;
                end
                OP_ST_RELOAD: begin
                    r_frames_left <= FRAMES_W'(div_quotient[RATE_W-9:0]);
                end
                OP_UPD_SHORT: begin
                    if (SHORT_IN_RING) begin
                        r_short_sum <= r_short_sum - SHORT_SUM_W'(drop_sample)
                                     + SHORT_SUM_W'(r_rate);
                    end
                end
                OP_UPD_MIDDLE: begin
                    if (MIDDLE_IN_RING) begin
                        r_middle_sum <= r_middle_sum - MIDDLE_SUM_W'(drop_sample)
                                      + MIDDLE_SUM_W'(r_rate);
                    end
                end
                OP_UPD_LONG: begin
                    r_long_sum <= r_long_sum - LONG_SUM_W'(drop_sample)
                                + LONG_SUM_W'(r_rate);
                    r_slot <= (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                            : r_slot + SLOT_W'(1);
                    if (!long_full) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    // The count saturates, and the sum freezes with it.
                    if (r_grand_count != '1) begin
                        r_grand_sum   <= r_grand_sum + GRAND_SUM_W'(r_rate);
                        r_grand_count <= r_grand_count + COUNT_W'(1);
                    end
                end
                OP_ST_SHORT: begin
                    r_held_short <= div_quotient;
                end
                OP_ST_MIDDLE: begin
                    r_held_middle <= div_quotient;
                end
                OP_ST_LONG: begin
                    r_held_long <= div_quotient;
                end
                OP_ST_GRAND: begin
                    r_held_overall <= div_quotient;
                    r_held_current <= r_rate;
                end
                default: begin
                    r_updated <= r_updated;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_updated <= r_updated;
            r_o_current <= r_held_current;
            r_o_short   <= r_held_short;
            r_o_middle  <= r_held_middle;
            r_o_long    <= r_held_long;
            r_o_overall <= r_held_overall;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_updated         = r_o_updated;
    assign o_current_rate    = r_o_current;
    assign o_short_average   = r_o_short;
    assign o_middle_average  = r_o_middle;
    assign o_long_average    = r_o_long;
    assign o_overall_average = r_o_overall;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= HISTORY_DEPTH)
        else $error("history fill count beyond ring depth");

    a_slot_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < HISTORY_DEPTH)
        else $error("write slot outside the ring");

    a_store_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_ST_RELOAD || i_ctrl.op == OP_ST_SHORT
         || i_ctrl.op == OP_ST_MIDDLE || i_ctrl.op == OP_ST_LONG
         || i_ctrl.op == OP_ST_GRAND) |-> !div_busy)
        else $error("quotient stored while the divider still runs");

    a_countdown_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_left >= -FRAMES_W'(1))
        else $error("frame countdown fell below minus one");

endmodule

@@ rtl/frame_rate_window_averager.sv @@
// Top level of the frame rate window averager: microcode sequencer plus datapath.
// A frame that takes no sample skips the divider and goes straight to the output register;
// a sampling frame runs the shared serial divider once for the countdown reload and once
// for each full window and the grand mean.
// A new transaction is accepted only once the previous result is in the output register.
// Reset (synchronous, active low) clears sums, counts, countdown and held results at once.
module frame_rate_window_averager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [frwa_pkg::SPS_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [frwa_pkg::RATE_W-1:0] i_frame_rate,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_updated,
    output logic [frwa_pkg::RATE_W-1:0] o_current_rate,
    output logic [frwa_pkg::RATE_W-1:0] o_short_average,
    output logic [frwa_pkg::RATE_W-1:0] o_middle_average,
    output logic [frwa_pkg::RATE_W-1:0] o_long_average,
    output logic [frwa_pkg::RATE_W-1:0] o_overall_average
);
    import frwa_pkg::*;

    // The sequencer walks a fixed program held in the package. Each step issues
    // one operation to the datapath and may jump on a status flag: waiting for a
    // transaction, skipping the sample path while the countdown is still positive,
    // holding while the divider iterates, skipping averages of windows that are
    // not yet full, and holding while the output register is still occupied.
    t_ctrl   ctrl;
    t_status status;

    frwa_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // The datapath owns the history ring, the running sums, the divider and the
    // output register, so a finished result can wait there while the next
    // transaction is already being accepted.
    frwa_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .i_frame_rate      (i_frame_rate),
        .i_out_ready       (i_out_ready),
        .o_in_ready        (o_in_ready),
        .o_out_valid       (o_out_valid),
        .o_updated         (o_updated),
        .o_current_rate    (o_current_rate),
        .o_short_average   (o_short_average),
        .o_middle_average  (o_middle_average),
        .o_long_average    (o_long_average),
        .o_overall_average (o_overall_average),
        .o_status          (status)
    );

endmodule

@@ tb/frame_rate_window_averager_tb.sv @@
// Self-checking testbench for the frame rate window averager: predicted per-frame results vs. DUT.
module frame_rate_window_averager_tb;
    import frwa_pkg::*;

    // A quiet stretch longer than this, with no transaction on either side, ends the run.
    // The slowest correct gap is the long receiver hold-off plus one sampling frame.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles allowed after the last result before a register write and at the very end.
    localparam int PHASE_SETTLE   = 8;
    localparam int END_SETTLE     = 160;
    // Length of the receiver hold-off that makes the block fill up and stall its input.
    localparam int LONG_HOLD      = 300;
    // Predictions waiting for their result; only a few are ever outstanding.
    localparam int PENDING_W      = 4;

    // One result transaction, field by field.
    typedef struct packed {
        logic              updated;
        logic [RATE_W-1:0] current_rate;
        logic [RATE_W-1:0] short_average;
        logic [RATE_W-1:0] middle_average;
        logic [RATE_W-1:0] long_average;
        logic [RATE_W-1:0] overall_average;
    } t_frame_result;

    // Every input is driven to a known value from time zero.
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [SPS_W-1:0]  i_cfg_wr_data = '0;
    logic              i_in_valid    = 1'b0;
    logic [RATE_W-1:0] i_frame_rate  = '0;
    logic              i_out_ready   = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_updated;
    logic [RATE_W-1:0] o_current_rate;
    logic [RATE_W-1:0] o_short_average;
    logic [RATE_W-1:0] o_middle_average;
    logic [RATE_W-1:0] o_long_average;
    logic [RATE_W-1:0] o_overall_average;

    // Predictor state, starting from the reset values of the block.
    logic [SPS_W-1:0]           model_sps         = SPS_RESET;
    logic signed [FRAMES_W-1:0] model_countdown   = '0;
    logic [RATE_W-1:0]          model_ring [HISTORY_DEPTH];
    logic [SLOT_W-1:0]          model_slot        = '0;
    logic [FILL_W-1:0]          model_fill        = '0;
    logic [SHORT_SUM_W-1:0]     model_short_sum   = '0;
    logic [MIDDLE_SUM_W-1:0]    model_middle_sum  = '0;
    logic [LONG_SUM_W-1:0]      model_long_sum    = '0;
    logic [GRAND_SUM_W-1:0]     model_grand_sum   = '0;
    logic [COUNT_W-1:0]         model_grand_count = '0;
    t_frame_result              model_held        = '0;

    // Results predicted for accepted frames, oldest first, in a small circular buffer.
    // The sender alone moves the write index and the checker alone the read index.
    t_frame_result          expected_results [2**PENDING_W];
    logic [PENDING_W-1:0]   pending_wr     = '0;
    logic [PENDING_W-1:0]   pending_rd     = '0;
    int                     mismatch_count = 0;
    int                     quiet_cycles   = 0;

    // Idle behavior of both sides; the tests switch these per phase.
    bit tx_idle       = 1'b1;
    bit rx_idle       = 1'b1;
    bit stall_drawn   = 1'b0;
    int stall_left    = 0;
    int stall_hold    = 0;
    // Handshake counts between processes; each one has a single writer.
    int taken_count   = 0;
    int taken_seen    = 0;
    int hold_requests = 0;
    int hold_served   = 0;

    frame_rate_window_averager dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_frame_rate     (i_frame_rate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_updated        (o_updated),
        .o_current_rate   (o_current_rate),
        .o_short_average  (o_short_average),
        .o_middle_average (o_middle_average),
        .o_long_average   (o_long_average),
        .o_overall_average(o_overall_average)
    );

    always #5 i_clk = ~i_clk;

    // Moves a window sum by one sample: the sample leaving the window (if the window is
    // already full) is taken out before the ring slot is overwritten.
    function automatic logic [63:0] slide_window(input logic [63:0] sum, input int window,
                                                 input logic [RATE_W-1:0] rate);
        if (window < 1 || window > HISTORY_DEPTH)
            return '0;
        if (32'(model_fill) >= window)
            sum -= 64'(model_ring[SLOT_W'((32'(model_slot) + HISTORY_DEPTH - window)
                                          % HISTORY_DEPTH)]);
        return sum + 64'(rate);
    endfunction

    // A window average stays zero until the window has seen enough samples.
    function automatic logic [RATE_W-1:0] window_mean(input logic [63:0] sum, input int window);
        if (window < 1 || window > HISTORY_DEPTH || 32'(model_fill) < window)
            return '0;
        return RATE_W'(sum / 64'(window));
    endfunction

    // Advances the predicted block by one frame and returns the result it must produce.
    function automatic t_frame_result advance_averager(input logic [RATE_W-1:0] rate);
        logic [SPS_W-1:0] div;
        model_held.updated = 1'b0;
        model_countdown = model_countdown - FRAMES_W'(1);
        if (model_countdown < FRAMES_W'(1)) begin
            // A divisor of zero acts as one; the reload is the integer part over the divisor.
            div = (model_sps == '0) ? SPS_W'(1) : model_sps;
            model_countdown = FRAMES_W'((rate >> 8) / RATE_W'(div));
            model_short_sum  = SHORT_SUM_W'(slide_window(64'(model_short_sum),
                                                         SHORT_WINDOW, rate));
            model_middle_sum = MIDDLE_SUM_W'(slide_window(64'(model_middle_sum),
                                                          MIDDLE_WINDOW, rate));
            model_long_sum   = LONG_SUM_W'(slide_window(64'(model_long_sum),
                                                        HISTORY_DEPTH, rate));
            model_ring[model_slot] = rate;
            model_slot = (model_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                       : model_slot + SLOT_W'(1);
            if (32'(model_fill) < HISTORY_DEPTH)
                model_fill = model_fill + FILL_W'(1);
            // The cumulative count saturates, freezing the overall mean.
            if (model_grand_count != '1) begin
                model_grand_sum   = model_grand_sum + GRAND_SUM_W'(rate);
                model_grand_count = model_grand_count + COUNT_W'(1);
            end
            model_held.updated         = 1'b1;
            model_held.current_rate    = rate;
            model_held.short_average   = window_mean(64'(model_short_sum), SHORT_WINDOW);
            model_held.middle_average  = window_mean(64'(model_middle_sum), MIDDLE_WINDOW);
            model_held.long_average    = window_mean(64'(model_long_sum), HISTORY_DEPTH);
            model_held.overall_average = RATE_W'(model_grand_sum
                                                 / GRAND_SUM_W'(model_grand_count));
        end
        return model_held;
    endfunction

    // Frames that will not sample carry any 24-bit value. A sampling frame mostly keeps
    // the reload at 0..3 frames so the windows fill and wrap often, and now and then
    // allows a reload up to 15 for larger sampled values.
    function automatic logic [RATE_W-1:0] pick_rate();
        int unsigned div;
        int unsigned span;
        int unsigned whole;
        if (model_countdown > FRAMES_W'(1))
            return RATE_W'($urandom());
        div   = (model_sps == '0) ? 1 : 32'(model_sps);
        span  = ($urandom_range(0, 15) == 0) ? 16 : 4;
        whole = $urandom_range(0, div * span - 1);
        return RATE_W'((whole << 8) | $urandom_range(0, 255));
    endfunction

    // Offers one frame after an optional gap and records its predicted result once the
    // transaction completes. Returns right after the accepting edge.
    task automatic send_frame(input logic [RATE_W-1:0] rate);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_rate <= rate;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results[pending_wr] = advance_averager(rate);
        pending_wr = pending_wr + PENDING_W'(1);
    endtask

    // Sends filler frames until the next frame is due to take a sample.
    task automatic run_to_sample();
        while (model_countdown > FRAMES_W'(1))
            send_frame(pick_rate());
    endtask

    // Stops offering frames and waits until every predicted result has arrived.
    task automatic drain(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_wr != pending_rd)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic set_samples_per_second(input logic [SPS_W-1:0] value);
        drain(PHASE_SETTLE);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        model_sps = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Right after reset the countdown is zero, so the first frame samples. Covers the
    // zero rate, a zero reload, a reload of two with a skipped all-ones frame.
    task automatic test_reset_state();
        send_frame(24'h000000);
        send_frame(24'h0003FF);
        send_frame(24'h000800);
        send_frame(24'hFFFFFF);
        send_frame(24'h0001AB);
        send_frame(24'h000400);
    endtask

    // A divisor of zero behaves as one.
    task automatic test_divisor_zero();
        set_samples_per_second('0);
        run_to_sample();
        send_frame(24'h0000FF);
        send_frame(24'h000201);
        send_frame(24'hFFFFFF);
        send_frame(24'h00007F);
        send_frame(24'h000100);
    endtask

    // Samples the largest rate with the largest divisor, rides out the long countdown
    // on random frames, then samples the smallest rate.
    task automatic test_peak_rate();
        set_samples_per_second('1);
        run_to_sample();
        send_frame(24'hFFFFFF);
        run_to_sample();
        send_frame(24'h000000);
        send_frame(24'h7FFFFF);
    endtask

    // Random frames under one register setting and one idle pattern.
    task automatic test_random_frames(input logic [SPS_W-1:0] sps, input int frames,
                                      input bit sender_gaps, input bit receiver_stalls);
        set_samples_per_second(sps);
        tx_idle = sender_gaps;
        rx_idle = receiver_stalls;
        repeat (frames) send_frame(pick_rate());
    endtask

    // The receiver holds off for a long stretch while frames keep coming back to back,
    // so the block fills up and has to stall its input.
    task automatic test_output_backpressure();
        drain(PHASE_SETTLE);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        @(posedge i_clk);
        hold_requests++;
        repeat (40) send_frame(pick_rate());
    endtask

    // Compares one result field and reports a mismatch.
    task automatic check_field(input string what, input logic [RATE_W-1:0] want,
                               input logic [RATE_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Every result transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            taken_count++;
            if (pending_wr == pending_rd) begin
                mismatch_count++;
                $display("%0t: result with no frame pending, expected none, got rate %h",
                         $time, o_current_rate);
            end else begin
                want = expected_results[pending_rd];
                pending_rd = pending_rd + PENDING_W'(1);
                check_field("updated", RATE_W'(want.updated), RATE_W'(o_updated));
                check_field("current_rate", want.current_rate, o_current_rate);
                check_field("short_average", want.short_average, o_short_average);
                check_field("middle_average", want.middle_average, o_middle_average);
                check_field("long_average", want.long_average, o_long_average);
                check_field("overall_average", want.overall_average, o_overall_average);
            end
        end
    end

    // Receiver: once a result shows up it may stall for a random number of cycles; a
    // long hold-off requested by a test takes precedence and is counted down here.
    always @(negedge i_clk) begin
        if (taken_seen != taken_count) begin
            taken_seen  = taken_count;
            stall_drawn = 1'b0;
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_hold  = LONG_HOLD;
        end
        if (o_out_valid && !stall_drawn) begin
            stall_drawn = 1'b1;
            stall_left  = rx_idle ? $urandom_range(0, 10) : 0;
        end
        if (stall_hold > 0) begin
            stall_hold--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("frame_rate_window_averager_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_divisor_zero();
        test_peak_rate();
        test_random_frames(SPS_W'(1), 200, 1'b1, 1'b1);
        test_random_frames(SPS_W'(64), 200, 1'b0, 1'b0);
        test_output_backpressure();
        test_random_frames(SPS_W'($urandom_range(2, 126)), 200, 1'b1, 1'b0);
        test_random_frames('0, 150, 1'b0, 1'b1);
        test_random_frames('1, 200, 1'b1, 1'b1);
        test_random_frames(SPS_W'($urandom_range(2, 63)), 100, 1'b1, 1'b1);

        drain(END_SETTLE);
        if (mismatch_count == 0)
            $display("frame_rate_window_averager_tb: PASS");
        else
            $display("frame_rate_window_averager_tb: FAIL");
        $finish;
    end

endmodule
